/* design/vram_bank_mapper_assert.svh */
// Assertion macros for the VRAM bank mapper.
`ifndef VRAM_BANK_MAPPER_ASSERT_SVH
`define VRAM_BANK_MAPPER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define VBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vbm check failed");

// Next-cycle implication, checked while out of reset.
`define VBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vbm check failed");

`endif

/* design/vbm_pkg.sv */
// Shared types, constants and decode functions for the VRAM bank mapper.
package vbm_pkg;

    localparam int NBANKS     = 9;
    localparam int NPAGES     = 89;
    localparam int AW         = 7;
    localparam int NSPANS     = 4;

    localparam logic [7:0] CTRL_EN    = 8'h80;
    localparam logic [2:0] MODE3_MASK = 3'h7;
    localparam logic [1:0] OFS_MASK   = 2'h3;

    localparam logic [AW-1:0] R_LCDC    = 7'd0;
    localparam logic [AW-1:0] R_ABG     = 7'd1;
    localparam logic [AW-1:0] R_AOBJ    = 7'd33;
    localparam logic [AW-1:0] R_BBG     = 7'd49;
    localparam logic [AW-1:0] R_BOBJ    = 7'd57;
    localparam logic [AW-1:0] R_ABGEXT  = 7'd65;
    localparam logic [AW-1:0] R_AOBJEXT = 7'd69;
    localparam logic [AW-1:0] R_BBGEXT  = 7'd70;
    localparam logic [AW-1:0] R_BOBJEXT = 7'd74;
    localparam logic [AW-1:0] R_TEX     = 7'd75;
    localparam logic [AW-1:0] R_TEXPAL  = 7'd79;
    localparam logic [AW-1:0] R_ARM7    = 7'd87;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // One contiguous run of page table entries
    typedef struct packed {
        logic [AW-1:0] base;
        logic [3:0]    len;
    } span_t;

    // Placement of one control byte: two runs and dirty flags
    typedef struct packed {
        span_t       s0;
        span_t       s1;
        logic [5:0]  dirty;
    } place_t;

    function automatic span_t mk(input logic [AW-1:0] b, input logic [3:0] l);
        span_t s;
        s.base = b;
        s.len  = l;
        return s;
    endfunction

    // Decode bank and control byte into page runs
    function automatic place_t decode(input logic [3:0] bank, input logic [7:0] c);
        place_t       p;
        logic [1:0]   ofs;
        logic [2:0]   fo;
        logic [AW-1:0] fi;
        ofs = c[4:3] & OFS_MASK;
        fo  = c[5:3];
        fi  = {4'd0, fo[1], 1'b0, fo[0]};
        p.s0 = mk(R_LCDC, 4'd0);
        p.s1 = mk(R_LCDC, 4'd0);
        p.dirty = 6'd0;
        unique case (bank)
            4'd0, 4'd1:
            begin
                unique case (c[1:0])
                    2'd0: p.s0 = mk(R_LCDC, 4'd1);
                    2'd1: p.s0 = mk(R_ABG + {2'd0, ofs, 3'd0}, 4'd8);
                    2'd2: p.s0 = mk(R_AOBJ + {3'd0, ofs[0], 3'd0}, 4'd8);
                    default: p.s0 = mk(R_TEX + {5'd0, ofs}, 4'd1);
                endcase
            end
            4'd2, 4'd3:
            begin
                unique case (c[2:0] & MODE3_MASK)
                    3'd0: p.s0 = mk(R_LCDC, 4'd1);
                    3'd1: p.s0 = mk(R_ABG + {2'd0, ofs, 3'd0}, 4'd8);
                    3'd2: p.s0 = mk(R_ARM7 + {6'd0, ofs[0]}, 4'd1);
                    3'd3: p.s0 = mk(R_TEX + {5'd0, ofs}, 4'd1);
                    3'd4: p.s0 = mk((bank == 4'd2) ? R_BBG : R_BOBJ, 4'd8);
                    default: p.s0 = mk(R_LCDC, 4'd0);
                endcase
            end
            4'd4:
            begin
                unique case (c[2:0])
                    3'd0: p.s0 = mk(R_LCDC, 4'd1);
                    3'd1: p.s0 = mk(R_ABG, 4'd4);
                    3'd2: p.s0 = mk(R_AOBJ, 4'd4);
                    3'd3: p.s0 = mk(R_TEXPAL, 4'd4);
                    3'd4:
                    begin
                        p.s0 = mk(R_ABGEXT, 4'd4);
                        p.dirty = 6'h03;
                    end
                    default: p.s0 = mk(R_LCDC, 4'd0);
                endcase
            end
            4'd5, 4'd6:
            begin
                unique case (c[2:0])
                    3'd0: p.s0 = mk(R_LCDC, 4'd1);
                    3'd1:
                    begin
                        p.s0 = mk(R_ABG + fi, 4'd1);
                        p.s1 = mk(R_ABG + fi + 7'd2, 4'd1);
                    end
                    3'd2:
                    begin
                        p.s0 = mk(R_AOBJ + fi, 4'd1);
                        p.s1 = mk(R_AOBJ + fi + 7'd2, 4'd1);
                    end
                    3'd3: p.s0 = mk(R_TEXPAL + fi, 4'd1);
                    3'd4:
                    begin
                        p.s0 = mk(R_ABGEXT + {5'd0, fo[0], 1'b0}, 4'd2);
                        p.dirty = {4'd0, fo[0], ~fo[0]};
                    end
                    3'd5:
                    begin
                        p.s0 = mk(R_AOBJEXT, 4'd1);
                        p.dirty = 6'h04;
                    end
                    default: p.s0 = mk(R_LCDC, 4'd0);
                endcase
            end
            4'd7:
            begin
                unique case (c[1:0])
                    2'd0: p.s0 = mk(R_LCDC, 4'd1);
                    2'd1:
                    begin
                        p.s0 = mk(R_BBG, 4'd2);
                        p.s1 = mk(R_BBG + 7'd4, 4'd2);
                    end
                    2'd2:
                    begin
                        p.s0 = mk(R_BBGEXT, 4'd4);
                        p.dirty = 6'h18;
                    end
                    default: p.s0 = mk(R_LCDC, 4'd0);
                endcase
            end
            default:
            begin
                unique case (c[1:0])
                    2'd0: p.s0 = mk(R_LCDC, 4'd1);
                    2'd1:
                    begin
                        p.s0 = mk(R_BBG + 7'd2, 4'd2);
                        p.s1 = mk(R_BBG + 7'd6, 4'd2);
                    end
                    2'd2: p.s0 = mk(R_BOBJ, 4'd8);
                    default:
                    begin
                        p.s0 = mk(R_BOBJEXT, 4'd1);
                        p.dirty = 6'h20;
                    end
                endcase
            end
        endcase
        return p;
    endfunction

    // Region base in the flat page table
    function automatic logic [AW-1:0] region_base(input logic [3:0] r);
        logic [AW-1:0] b;
        unique case (r)
            4'd0:  b = R_LCDC;
            4'd1:  b = R_ABG;
            4'd2:  b = R_AOBJ;
            4'd3:  b = R_BBG;
            4'd4:  b = R_BOBJ;
            4'd5:  b = R_ABGEXT;
            4'd6:  b = R_AOBJEXT;
            4'd7:  b = R_BBGEXT;
            4'd8:  b = R_BOBJEXT;
            4'd9:  b = R_TEX;
            4'd10: b = R_TEXPAL;
            4'd11: b = R_ARM7;
            default: b = R_LCDC;
        endcase
        return b;
    endfunction

    // Region size in pages; zero for unknown regions
    function automatic logic [5:0] region_size(input logic [3:0] r);
        logic [5:0] s;
        unique case (r)
            4'd0:  s = 6'd1;
            4'd1:  s = 6'd32;
            4'd2:  s = 6'd16;
            4'd3:  s = 6'd8;
            4'd4:  s = 6'd8;
            4'd5:  s = 6'd4;
            4'd6:  s = 6'd1;
            4'd7:  s = 6'd4;
            4'd8:  s = 6'd1;
            4'd9:  s = 6'd4;
            4'd10: s = 6'd8;
            4'd11: s = 6'd2;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

endpackage

/* design/vbm_page_ram.sv */
// Page table memory with per-entry valid bits; unwritten entries read zero.
module vbm_page_ram (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    we,
    input  logic [vbm_pkg::AW-1:0]  waddr,
    input  logic [vbm_pkg::NBANKS-1:0] wdata,
    input  logic [vbm_pkg::AW-1:0]  raddr,
    output logic [vbm_pkg::NBANKS-1:0] rdata
);

    logic [vbm_pkg::NBANKS-1:0] mem [vbm_pkg::NPAGES];
    logic [vbm_pkg::NPAGES-1:0] valid_reg;
    logic [vbm_pkg::NBANKS-1:0] rdata_reg;
    logic                       rvalid_reg;

    // Storage write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

/* design/vram_bank_mapper.sv */
// Top level of the VRAM bank mapper: sequencer, control registers, RMW unit.
//
// Usage: drive action/bank/control/region/page and pulse start while busy is
// low; the item transfers at that edge and busy rises. One result appears
// on the result ports for exactly one cycle with done high, then busy falls.
// Every item yields one result; the receiver cannot hold it off.
// A query reads the page table in its read state, then shows the result in
// the done state. A control write walks four page runs (unmap old, map new),
// each run passing a setup state and each page a read then a write through
// one shared read-modify-write unit on the page table memory, at most
// sixteen pages in all, before the done state.
// Busy falls right after done, so the next item can transfer at the end of
// the cycle after done; a new item is taken only once the last is through.
// A write to a bank past I or a write equal to the stored byte touches no
// page. Reset clears control bytes, ARM7 status and all page valid bits
// at once; no clearing pass is needed.
`include "vram_bank_mapper_assert.svh"
module vram_bank_mapper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       action,
    input  logic [3:0] bank,
    input  logic [7:0] control,
    input  logic [3:0] region,
    input  logic [4:0] page,
    output logic       done,
    output logic [8:0] bank_mask,
    output logic       page_valid,
    output logic [1:0] arm7_status,
    output logic [1:0] a_bg_pal_dirty,
    output logic       a_obj_pal_dirty,
    output logic [1:0] b_bg_pal_dirty,
    output logic       b_obj_pal_dirty
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SPAN = 6'b000010,
        S_RD   = 6'b000100,
        S_WR   = 6'b001000,
        S_QRD  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]                  ctrl_reg [vbm_pkg::NBANKS];
    vbm_pkg::span_t              span_reg [vbm_pkg::NSPANS];
    vbm_pkg::span_t              span_next [vbm_pkg::NSPANS];
    logic [vbm_pkg::NBANKS-1:0]  bmask_reg, bmask_next;
    logic [1:0]                  sidx_reg, sidx_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic [vbm_pkg::AW-1:0]      qaddr_reg, qaddr_next;
    logic                        query_reg, query_next;
    logic                        pvalid_reg, pvalid_next;
    logic [5:0]                  dirty_reg, dirty_next;
    logic [1:0]                  arm7_reg, arm7_next;

    logic                        accept;
    logic [7:0]                  old_ctrl;
    logic                        bank_ok;
    logic                        changed;
    vbm_pkg::place_t             old_pl, new_pl;
    vbm_pkg::span_t              cur;
    logic                        map_on;
    logic [vbm_pkg::AW-1:0]      pg_addr;
    logic [vbm_pkg::AW-1:0]      raddr;
    logic [vbm_pkg::NBANKS-1:0]  rdata, wdata;
    logic                        we;

    assign accept   = start && (state_reg == S_IDLE);
    assign bank_ok  = (bank < 4'(vbm_pkg::NBANKS));
    assign old_ctrl = bank_ok ? ctrl_reg[bank] : 8'd0;
    assign changed  = (old_ctrl != control);
    assign old_pl   = vbm_pkg::decode(bank, old_ctrl);
    assign new_pl   = vbm_pkg::decode(bank, control);

    // Shared read-modify-write unit on the current page
    assign cur     = span_reg[sidx_reg];
    assign map_on  = sidx_reg[1];
    assign pg_addr = cur.base + {4'd0, cnt_reg};
    assign raddr   = (state_reg == S_QRD) ? qaddr_reg : pg_addr;
    assign we      = (state_reg == S_WR);
    assign wdata   = map_on ? (rdata | bmask_reg) : (rdata & ~bmask_reg);

    vbm_page_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .waddr (pg_addr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        span_next   = span_reg;
        bmask_next  = bmask_reg;
        sidx_next   = sidx_reg;
        cnt_next    = cnt_reg;
        qaddr_next  = qaddr_reg;
        query_next  = query_reg;
        pvalid_next = pvalid_reg;
        dirty_next  = dirty_reg;
        arm7_next   = arm7_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    query_next  = (action == vbm_pkg::ACT_QUERY);
                    qaddr_next  = vbm_pkg::region_base(region) + {2'd0, page};
                    pvalid_next = ({1'b0, page} < vbm_pkg::region_size(region));
                    bmask_next  = vbm_pkg::NBANKS'(1) << bank;
                    sidx_next   = 2'd0;
                    cnt_next    = 3'd0;
                    dirty_next  = 6'd0;
                    for (int i = 0; i < vbm_pkg::NSPANS; i++)
                    begin
                        span_next[i] = vbm_pkg::mk(vbm_pkg::R_LCDC, 4'd0);
                    end
                    if (action == vbm_pkg::ACT_QUERY)
                    begin
                        state_next = S_QRD;
                    end
                    else
                    begin
                        pvalid_next = 1'b0;
                        state_next  = S_SPAN;
                        if (bank_ok && changed && old_ctrl[7])
                        begin
                            span_next[0] = old_pl.s0;
                            span_next[1] = old_pl.s1;
                            dirty_next   = dirty_next | old_pl.dirty;
                        end
                        if (bank_ok && changed && control[7])
                        begin
                            span_next[2] = new_pl.s0;
                            span_next[3] = new_pl.s1;
                            dirty_next   = dirty_next | new_pl.dirty;
                        end
                        // ARM7 status follows the stored C/D byte
                        if (bank == 4'd2 || bank == 4'd3)
                        begin
                            arm7_next[bank[0]] = ((control & vbm_pkg::CTRL_EN) != 8'd0)
                                && ((control[2:0] & vbm_pkg::MODE3_MASK) == 3'd2);
                        end
                    end
                end
            end
            S_SPAN:
            begin
                cnt_next = 3'd0;
                if (cur.len != 4'd0)
                begin
                    state_next = S_RD;
                end
                else if (sidx_reg == 2'(vbm_pkg::NSPANS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    sidx_next = sidx_reg + 2'd1;
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if ({1'b0, cnt_reg} == cur.len - 4'd1)
                begin
                    if (sidx_reg == 2'(vbm_pkg::NSPANS - 1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        sidx_next  = sidx_reg + 2'd1;
                        state_next = S_SPAN;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = S_RD;
                end
            end
            S_QRD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            arm7_reg  <= 2'd0;
            for (int i = 0; i < vbm_pkg::NBANKS; i++)
            begin
                ctrl_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            arm7_reg  <= arm7_next;
            if (accept && (action == vbm_pkg::ACT_WRITE) && bank_ok)
            begin
                ctrl_reg[bank] <= control;
            end
        end
    end

    // Work registers
    always_ff @(posedge clk)
    begin
        span_reg   <= span_next;
        bmask_reg  <= bmask_next;
        sidx_reg   <= sidx_next;
        cnt_reg    <= cnt_next;
        qaddr_reg  <= qaddr_next;
        query_reg  <= query_next;
        pvalid_reg <= pvalid_next;
        dirty_reg  <= dirty_next;
    end

    // Result ports
    assign busy            = (state_reg != S_IDLE);
    assign done            = (state_reg == S_DONE);
    assign bank_mask       = (query_reg && pvalid_reg) ? rdata : '0;
    assign page_valid      = query_reg && pvalid_reg;
    assign arm7_status     = arm7_reg;
    assign a_bg_pal_dirty  = query_reg ? 2'd0 : dirty_reg[1:0];
    assign a_obj_pal_dirty = query_reg ? 1'b0 : dirty_reg[2];
    assign b_bg_pal_dirty  = query_reg ? 2'd0 : dirty_reg[4:3];
    assign b_obj_pal_dirty = query_reg ? 1'b0 : dirty_reg[5];

    // Checks
    `VBM_ASSERT_NEXT(a_done_ends, done, !busy)
    `VBM_ASSERT_NOW(a_invalid_zero, done && !page_valid, bank_mask == 9'd0)
    `VBM_ASSERT_NOW(a_write_only_in_walk, we, busy && !query_reg)
    `VBM_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done)

endmodule
